@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 2 * CHAR_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_IDX_TEXT_ATTR = 1'b0;

    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd7;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;

    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
        logic [POS_W-1:0]  cursor_pos;
        logic              did_scroll;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_FINISH,
        ST_RDWAIT
    } state_t;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_CLEAR,
        JOB_SCROLL_NL,
        JOB_SCROLL_CHAR
    } job_t;

endpackage

@@ rtl/core/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read before write on a shared address.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer
// Put and newline requests that do not scroll, unused-opcode and out-of-range
// read requests answer in the cycle after acceptance and leave busy low, so
// they can follow back to back. An in-range read answers through the
// registered port of the screen store and the ST_RDWAIT state. A scroll or
// clear sweeps the store once, one cell a cycle, then passes ST_FLUSH and
// ST_FINISH before the answer, with busy high meanwhile. After reset a
// clearing pass over the whole store holds busy high.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             start,
    input  tcw_pkg::req_t                    req,
    output logic                             busy,
    // answer channel, one strobe per request
    output logic                             rsp_valid,
    output tcw_pkg::rsp_t                    rsp,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    `include "assert_macros.svh"

    // Geometry
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int LAST_START = COLUMNS * (ROWS - 1);
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CUR_W      = $clog2(CELLS + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS + 1);

    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(LAST_START);
    localparam logic [ADDR_W-1:0] END_A  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
    localparam logic [CUR_W-1:0]  LAST_C = CUR_W'(LAST_START);
    localparam logic [CUR_W-1:0]  CELLS_C = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0]  COLS_C = CUR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_END = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_PAST = ROW_W'(ROWS);

    // Sequencer state
    tcw_pkg::state_t state_reg, state_next;
    tcw_pkg::job_t   job_reg, job_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    // Trailing write of the sweep: the cell read in the previous cycle lands here.
    logic              pend_reg, pend_next;
    logic              pend_zero_reg, pend_zero_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    // Character held while a scroll runs ahead of its write
    logic [tcw_pkg::CHAR_W-1:0] char_reg, char_next;

    // Cursor kept both as linear position and as row/column
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic [tcw_pkg::CHAR_W-1:0] attr_reg, attr_next;

    logic          rsp_valid_reg, rsp_valid_next;
    tcw_pkg::rsp_t rsp_reg, rsp_next;

    // Screen store ports
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    logic cfg_hit;
    logic cfg_wr;

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Register port: one attribute register, always ready.
    // ------------------------------------------------------------------------
    assign cfg_hit = (paddr[tcw_pkg::APB_ADDR_W-1:2] == tcw_pkg::REG_IDX_TEXT_ATTR);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? tcw_pkg::APB_DATA_W'(attr_reg) : '0;

    always_comb
    begin
        attr_next = attr_reg;
        if (cfg_wr && cfg_hit)
        begin
            attr_next = pwdata[tcw_pkg::CHAR_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // start in the clearing pass over the whole store
            state_reg     <= tcw_pkg::ST_SWEEP;
            job_reg       <= tcw_pkg::JOB_INIT;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            cursor_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            cursor_reg    <= cursor_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            attr_reg      <= attr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_zero_reg <= pend_zero_next;
        pend_addr_reg <= pend_addr_next;
        char_reg      <= char_next;
        rsp_reg       <= rsp_next;
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state, store access and answers
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        sweep_next     = sweep_reg;
        pend_next      = 1'b0;
        pend_zero_next = pend_zero_reg;
        pend_addr_next = pend_addr_reg;
        char_next      = char_reg;
        cursor_next    = cursor_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;

        // Default store traffic: drain the trailing sweep write, and read the
        // cell one row below the sweep position.
        ram_we    = pend_reg;
        ram_waddr = pend_addr_reg;
        ram_wdata = pend_zero_reg ? '0 : ram_rdata;
        ram_raddr = sweep_reg + COLS_A;

        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // Answer next cycle unless a sweep or a store read is launched below.
                    rsp_valid_next      = 1'b1;
                    rsp_next.cell_char  = '0;
                    rsp_next.cell_attr  = '0;
                    rsp_next.did_scroll = 1'b0;

                    case (req.opcode)
                        tcw_pkg::OP_PUT:
                        begin
                            if (req.char_code == tcw_pkg::NEWLINE_CODE)
                            begin
                                if (row_reg >= ROW_LAST)
                                begin
                                    // newline off the bottom: scroll
                                    state_next     = tcw_pkg::ST_SWEEP;
                                    job_next       = tcw_pkg::JOB_SCROLL_NL;
                                    sweep_next     = '0;
                                    rsp_valid_next = 1'b0;
                                end
                                else
                                begin
                                    // advance to the start of the next row
                                    cursor_next = cursor_reg + COLS_C - CUR_W'(col_reg);
                                    row_next    = row_reg + 1'b1;
                                    col_next    = '0;
                                end
                            end
                            else if (req.char_code != tcw_pkg::NULL_CODE)
                            begin
                                if (row_reg == ROW_PAST)
                                begin
                                    // cursor past the last cell: scroll first,
                                    // write the character at the end
                                    state_next     = tcw_pkg::ST_SWEEP;
                                    job_next       = tcw_pkg::JOB_SCROLL_CHAR;
                                    sweep_next     = '0;
                                    char_next      = req.char_code;
                                    rsp_valid_next = 1'b0;
                                end
                                else
                                begin
                                    ram_we      = 1'b1;
                                    ram_waddr   = ADDR_W'(cursor_reg);
                                    ram_wdata   = {attr_reg, req.char_code};
                                    cursor_next = cursor_reg + 1'b1;
                                    if (col_reg == COL_END)
                                    begin
                                        col_next = '0;
                                        row_next = row_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        col_next = col_reg + 1'b1;
                                    end
                                end
                            end
                        end

                        tcw_pkg::OP_CLEAR:
                        begin
                            state_next     = tcw_pkg::ST_SWEEP;
                            job_next       = tcw_pkg::JOB_CLEAR;
                            sweep_next     = '0;
                            rsp_valid_next = 1'b0;
                        end

                        tcw_pkg::OP_READ:
                        begin
                            // out-of-range reads answer zero right away
                            if (32'(req.cell_index) < 32'(CELLS))
                            begin
                                ram_raddr      = ADDR_W'(req.cell_index);
                                state_next     = tcw_pkg::ST_RDWAIT;
                                rsp_valid_next = 1'b0;
                            end
                        end

                        default:
                        begin
                        end
                    endcase

                    rsp_next.cursor_pos = tcw_pkg::POS_W'(cursor_next);
                end
            end

            tcw_pkg::ST_SWEEP:
            begin
                // Queue the write for this cell; it lands next cycle with the
                // cell from one row below, or zero for the bottom row and for
                // a full clear.
                pend_next      = 1'b1;
                pend_addr_next = sweep_reg;
                pend_zero_next = (job_reg == tcw_pkg::JOB_INIT)
                              || (job_reg == tcw_pkg::JOB_CLEAR)
                              || (sweep_reg >= LAST_A);
                if (sweep_reg == END_A)
                begin
                    state_next = tcw_pkg::ST_FLUSH;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            tcw_pkg::ST_FLUSH:
            begin
                // last trailing write drains here
                state_next = tcw_pkg::ST_FINISH;
            end

            tcw_pkg::ST_FINISH:
            begin
                state_next          = tcw_pkg::ST_IDLE;
                rsp_valid_next      = 1'b1;
                rsp_next.cell_char  = '0;
                rsp_next.cell_attr  = '0;
                rsp_next.did_scroll = 1'b1;

                case (job_reg)
                    tcw_pkg::JOB_INIT:
                    begin
                        // power-up pass answers nothing
                        rsp_valid_next = 1'b0;
                    end

                    tcw_pkg::JOB_CLEAR:
                    begin
                        cursor_next         = '0;
                        row_next            = '0;
                        col_next            = '0;
                        rsp_next.did_scroll = 1'b0;
                    end

                    tcw_pkg::JOB_SCROLL_NL:
                    begin
                        cursor_next = LAST_C;
                        row_next    = ROW_LAST;
                        col_next    = '0;
                    end

                    tcw_pkg::JOB_SCROLL_CHAR:
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = LAST_A;
                        ram_wdata   = {attr_reg, char_reg};
                        cursor_next = LAST_C + 1'b1;
                        row_next    = ROW_LAST;
                        col_next    = COL_W'(1);
                    end

                    default:
                    begin
                    end
                endcase

                rsp_next.cursor_pos = tcw_pkg::POS_W'(cursor_next);
            end

            tcw_pkg::ST_RDWAIT:
            begin
                // registered read data is here now
                state_next          = tcw_pkg::ST_IDLE;
                rsp_valid_next      = 1'b1;
                rsp_next.cell_char  = ram_rdata[tcw_pkg::CHAR_W-1:0];
                rsp_next.cell_attr  = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                rsp_next.cursor_pos = tcw_pkg::POS_W'(cursor_reg);
                rsp_next.did_scroll = 1'b0;
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != tcw_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_answers, clk, rst_n, start && !busy, rsp_valid || busy)
    `ASSERT_IMPLIES(a_idle_no_pend, clk, rst_n, state_reg == tcw_pkg::ST_IDLE, !pend_reg)
    `ASSERT_IMPLIES(a_cursor_range, clk, rst_n, 1'b1, (cursor_reg <= CELLS_C) && (32'(col_reg) < 32'(COLUMNS)))
    `ASSERT_IMPLIES(a_scroll_bottom, clk, rst_n, rsp_valid && rsp.did_scroll, row_reg == ROW_LAST)

endmodule

@@ sim/console_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_checker
// Watches the request, answer and register channels of the text console
// writer, keeps a shadow screen and cursor, and compares every answer with
// the prediction made when its request was accepted.
// ----------------------------------------------------------------------------
module console_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_ROW  = COLUMNS * (ROWS - 1);

    logic [CELL_W-1:0] shadow_screen [CELLS];
    int                shadow_cursor;
    logic [CHAR_W-1:0] shadow_attr;
    rsp_t              expected_answers [$];

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = '0;
    endfunction

    // move every row up by one, blank the bottom row, park the cursor there
    function automatic void scroll_screen();
        for (int i = 0; i < LAST_ROW; i++)
            shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = LAST_ROW; i < CELLS; i++)
            shadow_screen[i] = '0;
        shadow_cursor = LAST_ROW;
    endfunction

    function automatic rsp_t console_answer(req_t r);
        rsp_t a;
        a = '0;
        case (r.opcode)
            OP_PUT:
            begin
                if (r.char_code == NEWLINE_CODE)
                begin
                    shadow_cursor = COLUMNS * (shadow_cursor / COLUMNS + 1);
                    if (shadow_cursor > CELLS - 1)
                    begin
                        scroll_screen();
                        a.did_scroll = 1'b1;
                    end
                end
                else if (r.char_code != NULL_CODE)
                begin
                    if (shadow_cursor > CELLS - 1)
                    begin
                        scroll_screen();
                        a.did_scroll = 1'b1;
                    end
                    shadow_screen[shadow_cursor] = {shadow_attr, r.char_code};
                    shadow_cursor++;
                end
            end
            OP_CLEAR:
            begin
                blank_screen();
                shadow_cursor = 0;
            end
            OP_READ:
            begin
                if (r.cell_index < CELLS)
                    {a.cell_attr, a.cell_char} = shadow_screen[r.cell_index];
            end
            default: ;
        endcase
        a.cursor_pos = shadow_cursor[POS_W-1:0];
        return a;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            blank_screen();
            shadow_cursor = 0;
            shadow_attr   = ATTR_RESET;
            expected_answers.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_IDX_TEXT_ATTR)
                shadow_attr = pwdata[CHAR_W-1:0];

            if (start && !busy)
                expected_answers.push_back(console_answer(req));

            if (rsp_valid)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: answer with nothing expected, got %p", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("cell_char",  32'(want.cell_char),  32'(rsp.cell_char));
                    check_field("cell_attr",  32'(want.cell_attr),  32'(rsp.cell_attr));
                    check_field("cursor_pos", 32'(want.cursor_pos), 32'(rsp.cursor_pos));
                    check_field("did_scroll", 32'(want.did_scroll), 32'(rsp.did_scroll));
                end
            end
            pending <= expected_answers.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives put, clear, read and unused-opcode requests into the text console
// writer, first a short directed list and then random phases of text with
// newlines, reads and rare clears, rewriting the attribute register between
// phases. A separate checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    localparam int CELLS          = COLUMNS_DEF * ROWS_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 250;
    // longest legal silence is one sweep plus a gap
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 10;

    // opcode 3 has no operation behind it
    localparam logic [OPCODE_W-1:0]   OP_UNUSED     = 2'd3;
    // second register slot, not implemented
    localparam logic [APB_ADDR_W-3:0] REG_IDX_SPARE = 1'b1;
    localparam logic [APB_ADDR_W-1:0] ADDR_TEXT_ATTR = {REG_IDX_TEXT_ATTR, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE     = {REG_IDX_SPARE, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    req_t                  req;
    logic                  busy;
    logic                  rsp_valid;
    rsp_t                  rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int quiet_cycles;
    bit gaps_on;

    text_console_char_writer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    console_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles without any request accepted or answer delivered; a stuck
    // block ends the run here.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || rsp_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Random idle
    // cycles may come first, each with the same chance, so about one cycle in
    // five is idle; start is only lowered in a step where it is not raised.
    task automatic issue(input req_t r);
        if (gaps_on)
        begin
            while ($urandom_range(99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic issue_fields(input logic [OPCODE_W-1:0] op,
                                input logic [CHAR_W-1:0] code,
                                input logic [INDEX_W-1:0] index);
        issue(req_t'{op, code, index});
    endtask

    // Drop start and wait until every request has been answered. The count
    // from the checker is registered, so always advance before looking.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Register write: a setup phase, then an access phase; pready is always high.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly running text with newlines and reads, so the cursor reaches the
    // bottom and the screen scrolls; clears are rare because each one resets
    // the cursor and costs a full sweep. Fields a request ignores stay random.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r.opcode     = OP_PUT;
        r.char_code  = CHAR_W'($urandom_range(255));
        r.cell_index = INDEX_W'($urandom_range(2047));
        pick = $urandom_range(999);
        if (pick < 560)
            r.char_code = CHAR_W'($urandom_range(255, 1));
        else if (pick < 640)
            r.char_code = NEWLINE_CODE;
        else if (pick < 660)
            r.char_code = NULL_CODE;
        else if (pick < 662)
            r.opcode = OP_CLEAR;
        else if (pick < 690)
            r.opcode = OP_UNUSED;
        else
        begin
            r.opcode = OP_READ;
            if (pick < 970)
                r.cell_index = INDEX_W'($urandom_range(CELLS - 1));
            else
                r.cell_index = INDEX_W'($urandom_range(2047, CELLS));
        end
        return r;
    endfunction

    initial
    begin
        logic [APB_DATA_W-1:0] attr;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        gaps_on = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: blank read, extreme codes, null, reads at both ends and
        // out of range, unused opcode, newline, clear with noisy fields.
        issue_fields(OP_READ,   8'h00,        11'd0);
        issue_fields(OP_PUT,    8'h48,        11'd0);
        issue_fields(OP_PUT,    8'hFF,        11'd0);
        issue_fields(OP_PUT,    8'h01,        11'h7FF);
        issue_fields(OP_PUT,    NULL_CODE,    11'h7FF);
        issue_fields(OP_READ,   8'hFF,        11'd0);
        issue_fields(OP_READ,   8'h00,        11'd1);
        issue_fields(OP_READ,   8'h00,        11'd2);
        issue_fields(OP_READ,   8'h00,        11'd3);
        issue_fields(OP_READ,   8'h00,        11'(CELLS - 1));
        issue_fields(OP_READ,   8'h00,        11'(CELLS));
        issue_fields(OP_READ,   8'h00,        11'h7FF);
        issue_fields(OP_UNUSED, 8'hFF,        11'h7FF);
        issue_fields(OP_UNUSED, 8'h00,        11'd0);
        issue_fields(OP_PUT,    NEWLINE_CODE, 11'd0);
        issue_fields(OP_PUT,    8'h7E,        11'd0);
        issue_fields(OP_READ,   8'h00,        11'(COLUMNS_DEF));
        issue_fields(OP_CLEAR,  8'hAA,        11'h555);
        issue_fields(OP_READ,   8'h00,        11'd0);
        issue_fields(OP_READ,   8'h00,        11'(COLUMNS_DEF));
        issue_fields(OP_PUT,    8'h80,        11'h2AA);
        drain();

        // Random phases; the attribute changes between them, extremes first.
        // The third phase runs without gaps.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       attr = 32'h0000_0000;
                1:       attr = 32'h0000_00FF;
                default: attr = $urandom;
            endcase
            if (phase == 1)
                write_reg(ADDR_SPARE, $urandom);
            write_reg(ADDR_TEXT_ATTR, attr);
            gaps_on = (phase != 2);
            repeat (PHASE_REQUESTS) issue(random_request());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
